// File: sv/mrt_pkg.sv
// Shared types and codes for the masked route table.
// Holds the beat structs, the search token that walks the cell row and the status codes.
// No dependencies.
package mrt_pkg;

  // Default number of route slots
  localparam int unsigned ROUTE_ENTRIES_DEF = 16;

  // Item function codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_MATCH = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_ADDED = 3'd0;
  localparam logic [2:0] ST_DUP   = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_HIT   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;

  // Input beat
  typedef struct packed {
    logic        func;
    logic [31:0] addr;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [7:0]  port;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_port;
    logic [31:0] out_gateway;
    logic [31:0] next_hop;
  } out_beat_t;

  // Search token handed from cell to cell, newest slot first.
  // On an add, addr carries the already masked destination.
  typedef struct packed {
    logic        live;
    logic        func;
    logic [31:0] addr;
    logic [31:0] mask;
    logic        found;
    logic [7:0]  port;
    logic [31:0] gateway;
  } tok_t;

  // Route written into one slot
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gateway;
    logic [7:0]  port;
  } wr_t;

endpackage

// File: sv/mrt_cell.sv
// One slot of the route table with its stage of the search row.
// Holds a single route and compares the passing token against it.
// Depends on mrt_pkg.
module mrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  mrt_pkg::wr_t wr_data,
  input  mrt_pkg::tok_t tok_i,
  output mrt_pkg::tok_t tok_o
);
  import mrt_pkg::*;

  logic        valid_r;
  logic [31:0] dest_r;
  logic [31:0] mask_r;
  logic [31:0] gateway_r;
  logic [7:0]  port_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        hit;

  // Compare: prefix match on a lookup, exact route match on an add
  always_comb begin
    if (tok_i.func == FUNC_MATCH) begin
      hit = valid_r && ((tok_i.addr & mask_r) == dest_r);
    end else begin
      hit = valid_r && (dest_r == tok_i.addr) && (mask_r == tok_i.mask);
    end
  end

  // Claim the token on the first hit, otherwise pass it on unchanged
  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.live && !tok_i.found && hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.port    = port_r;
      tok_nxt.gateway = gateway_r;
    end
  end

  // Control: slot valid and token presence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      tok_r.live <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r <= 1'b1;
      end
      tok_r.live <= tok_nxt.live;
    end
  end

  // Payload: route fields and token contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dest_r    <= wr_data.dest;
      mask_r    <= wr_data.mask;
      gateway_r <= wr_data.gateway;
      port_r    <= wr_data.port;
    end
    tok_r.func    <= tok_nxt.func;
    tok_r.addr    <= tok_nxt.addr;
    tok_r.mask    <= tok_nxt.mask;
    tok_r.found   <= tok_nxt.found;
    tok_r.port    <= tok_nxt.port;
    tok_r.gateway <= tok_nxt.gateway;
  end

  assign tok_o = tok_r;

endmodule

// File: sv/masked_route_table.sv
// Masked route table: an IPv4 static route table with newest-first matching.
// Top level; instantiates a row of mrt_cell slots and uses mrt_pkg.
//
// Routes live in a row of ROUTE_ENTRIES cells, filled in add order. Each item
// sends a search token along the row from the newest slot to the oldest, one
// cell per cycle, from the launch register through the cells into the finish
// stage, where the result beat is built and loaded. The block works on one
// item at a time and takes the next item only after the result beat of the
// last is loaded.
// A lookup returns the newest route whose mask applied to the address equals
// its destination; an add is refused as a duplicate when the same masked
// destination and mask are already present, else as full when every slot is
// used. The result beat sits in an output register, so a stalled result does
// not hold up the search of the next item, only the loading of its result.
module masked_route_table #(
  parameter int unsigned ROUTE_ENTRIES = mrt_pkg::ROUTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrt_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mrt_pkg::out_beat_t out_data
);
  import mrt_pkg::*;

  localparam int unsigned CW = $clog2(ROUTE_ENTRIES + 1);

  logic                     busy_r;
  tok_t                     tok_in_r;
  logic                     fin_valid_r;
  tok_t                     fin_tok_r;
  wr_t                      item_r;
  logic [CW-1:0]            count_r;
  logic                     out_valid_r;
  out_beat_t                out_data_r;
  tok_t                     link [ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES-1:0] wr_en;
  logic                     accept;
  logic                     out_free;
  logic                     fin_go;
  logic                     full;
  logic                     do_write;
  out_beat_t                result;

  assign accept   = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign fin_go   = fin_valid_r && out_free;
  assign full     = (count_r == CW'(ROUTE_ENTRIES));
  assign do_write = fin_go && (fin_tok_r.func == FUNC_ADD) && !fin_tok_r.found && !full;

  // Row of slots; the token enters at the newest end
  for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_cell
    assign wr_en[k] = do_write && (count_r == CW'(k));
    if (k == ROUTE_ENTRIES - 1) begin : g_head
      mrt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en[k]),
        .wr_data (item_r),
        .tok_i   (tok_in_r),
        .tok_o   (link[k])
      );
    end else begin : g_body
      mrt_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en[k]),
        .wr_data (item_r),
        .tok_i   (link[k+1]),
        .tok_o   (link[k])
      );
    end
  end

  // Build the result beat from the finished token
  always_comb begin
    result.status      = ST_MISS;
    result.out_port    = '0;
    result.out_gateway = '0;
    result.next_hop    = '0;
    if (fin_tok_r.func == FUNC_ADD) begin
      if (fin_tok_r.found) begin
        result.status = ST_DUP;
      end else if (full) begin
        result.status = ST_FULL;
      end else begin
        result.status = ST_ADDED;
      end
    end else if (fin_tok_r.found) begin
      result.status      = ST_HIT;
      result.out_port    = fin_tok_r.port;
      result.out_gateway = fin_tok_r.gateway;
      result.next_hop    = (fin_tok_r.gateway != 32'd0) ? fin_tok_r.gateway : fin_tok_r.addr;
    end
  end

  // Control: item in flight, token launch, finish stage, fill count, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      tok_in_r.live <= 1'b0;
      fin_valid_r   <= 1'b0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      tok_in_r.live <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (link[0].live) begin
        fin_valid_r <= 1'b1;
      end
      if (fin_go) begin
        fin_valid_r <= 1'b0;
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (do_write) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Payload: launched token, held route, finished token, result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      tok_in_r.func    <= in_data.func;
      tok_in_r.addr    <= (in_data.func == FUNC_ADD) ? (in_data.addr & in_data.netmask)
                                                     : in_data.addr;
      tok_in_r.mask    <= in_data.netmask;
      tok_in_r.found   <= 1'b0;
      tok_in_r.port    <= '0;
      tok_in_r.gateway <= '0;
      item_r.dest      <= in_data.addr & in_data.netmask;
      item_r.mask      <= in_data.netmask;
      item_r.gateway   <= in_data.gateway;
      item_r.port      <= in_data.port;
    end
    if (link[0].live) begin
      fin_tok_r <= link[0];
    end
    if (fin_go) begin
      out_data_r <= result;
    end
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
